@@ rtl/assert_macros.svh @@
// Assertion helpers used by the top-level RTL file.
// Both expect clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/ests_pkg.sv @@
package ests_pkg;

    localparam int REG_IDX_BITS = 3;
    localparam int ADDR_BITS    = 5;
    localparam int ROM_WORD     = 15;
    localparam int ENV_BITS     = 25;
    localparam int PEAK_BITS    = 15;
    localparam int LEN_BITS     = 24;
    localparam int PROD_BITS    = 40;

    localparam logic [REG_IDX_BITS-1:0] REG_PHASE_STEP     = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_PEAK_AMPLITUDE = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_ATTACK_LENGTH  = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_SUSTAIN_LENGTH = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_DECAY_LENGTH   = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_ATTACK_STEP    = 3'd5;
    localparam logic [REG_IDX_BITS-1:0] REG_DECAY_STEP     = 3'd6;
    localparam logic [REG_IDX_BITS-1:0] REG_TOTAL_SAMPLES  = 3'd7;

    localparam logic [31:0]          RST_PHASE_STEP     = 32'd42852281;
    localparam logic [PEAK_BITS-1:0] RST_PEAK_AMPLITUDE = 15'd22938;
    localparam logic [LEN_BITS-1:0]  RST_ATTACK_LENGTH  = 24'd2867;
    localparam logic [LEN_BITS-1:0]  RST_SUSTAIN_LENGTH = 24'd44100;
    localparam logic [LEN_BITS-1:0]  RST_DECAY_LENGTH   = 24'd2867;
    localparam logic [ENV_BITS-1:0]  RST_ATTACK_STEP    = 25'd5853;
    localparam logic [ENV_BITS-1:0]  RST_DECAY_STEP     = 25'd5853;
    localparam logic [LEN_BITS-1:0]  RST_TOTAL_SAMPLES  = 24'd88200;

    localparam logic [ENV_BITS-1:0] ENV_ONE = 25'h100_0000;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] SINE_DIV [5] = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

    typedef logic mul_op_t;
    localparam mul_op_t MUL_AMP = 1'b0;
    localparam mul_op_t MUL_MAG = 1'b1;

    typedef struct packed {
        logic    en;
        mul_op_t op;
    } mul_ctl_t;

    typedef struct packed {
        logic [31:0]          phase_step;
        logic [PEAK_BITS-1:0] peak_amplitude;
        logic [LEN_BITS-1:0]  attack_length;
        logic [LEN_BITS-1:0]  sustain_length;
        logic [LEN_BITS-1:0]  decay_length;
        logic [ENV_BITS-1:0]  attack_step;
        logic [ENV_BITS-1:0]  decay_step;
        logic [LEN_BITS-1:0]  total_samples;
    } cfg_t;

    // quarter-wave entry k, Taylor series evaluated in Q2.30
    function automatic logic [ROM_WORD-1:0] rom_entry(int unsigned k, int unsigned tbits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] v;
        x  = (HALF_PI_Q30 * ((64'(k) << 1) + 64'd1)) >> (tbits + 1);
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        for (int n = 0; n < 5; n++)
        begin
            t = Q30_ONE - (((x2 * t) >> 30) / SINE_DIV[n]);
        end
        s = (x * t) >> 30;
        v = (s + 64'd16384) >> 15;
        if (v > 64'd32767)
        begin
            v = 64'd32767;
        end
        return v[ROM_WORD-1:0];
    endfunction

endpackage

@@ rtl/ests_regs.sv @@
module ests_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ests_pkg::ADDR_BITS-1:0]     paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    output ests_pkg::cfg_t                     cfg
);

    ests_pkg::cfg_t                        cfg_reg;
    logic [ests_pkg::REG_IDX_BITS-1:0]     idx;
    logic                                  wr_en;

    assign idx    = paddr[ests_pkg::ADDR_BITS-1:2];
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_step     <= ests_pkg::RST_PHASE_STEP;
            cfg_reg.peak_amplitude <= ests_pkg::RST_PEAK_AMPLITUDE;
            cfg_reg.attack_length  <= ests_pkg::RST_ATTACK_LENGTH;
            cfg_reg.sustain_length <= ests_pkg::RST_SUSTAIN_LENGTH;
            cfg_reg.decay_length   <= ests_pkg::RST_DECAY_LENGTH;
            cfg_reg.attack_step    <= ests_pkg::RST_ATTACK_STEP;
            cfg_reg.decay_step     <= ests_pkg::RST_DECAY_STEP;
            cfg_reg.total_samples  <= ests_pkg::RST_TOTAL_SAMPLES;
        end
        else if (wr_en)
        begin
            unique case (idx)
                ests_pkg::REG_PHASE_STEP:     cfg_reg.phase_step     <= pwdata;
                ests_pkg::REG_PEAK_AMPLITUDE: cfg_reg.peak_amplitude <= pwdata[14:0];
                ests_pkg::REG_ATTACK_LENGTH:  cfg_reg.attack_length  <= pwdata[23:0];
                ests_pkg::REG_SUSTAIN_LENGTH: cfg_reg.sustain_length <= pwdata[23:0];
                ests_pkg::REG_DECAY_LENGTH:   cfg_reg.decay_length   <= pwdata[23:0];
                ests_pkg::REG_ATTACK_STEP:    cfg_reg.attack_step    <= pwdata[24:0];
                ests_pkg::REG_DECAY_STEP:     cfg_reg.decay_step     <= pwdata[24:0];
                ests_pkg::REG_TOTAL_SAMPLES:  cfg_reg.total_samples  <= pwdata[23:0];
                default:                      cfg_reg                <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            ests_pkg::REG_PHASE_STEP:     prdata = cfg_reg.phase_step;
            ests_pkg::REG_PEAK_AMPLITUDE: prdata = 32'(cfg_reg.peak_amplitude);
            ests_pkg::REG_ATTACK_LENGTH:  prdata = 32'(cfg_reg.attack_length);
            ests_pkg::REG_SUSTAIN_LENGTH: prdata = 32'(cfg_reg.sustain_length);
            ests_pkg::REG_DECAY_LENGTH:   prdata = 32'(cfg_reg.decay_length);
            ests_pkg::REG_ATTACK_STEP:    prdata = 32'(cfg_reg.attack_step);
            ests_pkg::REG_DECAY_STEP:     prdata = 32'(cfg_reg.decay_step);
            ests_pkg::REG_TOTAL_SAMPLES:  prdata = 32'(cfg_reg.total_samples);
            default:                      prdata = '0;
        endcase
    end

endmodule

@@ rtl/ests_rom.sv @@
module ests_rom #(
    parameter int TABLE_BITS = 10
) (
    input  logic                          clk,
    input  logic                          rd_en,
    input  logic [TABLE_BITS-1:0]         addr,
    output logic [ests_pkg::ROM_WORD-1:0] data
);

    localparam int ROM_SIZE = 1 << TABLE_BITS;
    localparam int WORD     = ests_pkg::ROM_WORD;

    function automatic logic [ROM_SIZE*WORD-1:0] build_rom();
        logic [ROM_SIZE*WORD-1:0] bits;
        bits = '0;
        for (int k = 0; k < ROM_SIZE; k++)
        begin
            bits[k*WORD +: WORD] = ests_pkg::rom_entry(k, TABLE_BITS);
        end
        return bits;
    endfunction

    localparam logic [ROM_SIZE*WORD-1:0] ROM_BITS = build_rom();

    logic [WORD-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            data_reg <= ROM_BITS[addr*WORD +: WORD];
        end
    end

    assign data = data_reg;

endmodule

@@ rtl/ests_mul.sv @@
module ests_mul (
    input  logic                                 clk,
    input  ests_pkg::mul_ctl_t                   ctl,
    input  logic [ests_pkg::ENV_BITS-1:0]        env,
    input  logic [ests_pkg::PEAK_BITS-1:0]       peak,
    input  logic [ests_pkg::ROM_WORD-1:0]        rom,
    output logic [ests_pkg::PROD_BITS-1:0]       prod
);

    localparam int PW = ests_pkg::PROD_BITS;
    localparam int EW = ests_pkg::ENV_BITS;
    localparam int BW = ests_pkg::PEAK_BITS;

    logic [PW-1:0] prod_reg;
    logic [PW-1:0] amp_sum;
    logic [EW-1:0] op_a;
    logic [BW-1:0] op_b;

    // amplitude = round(peak * env / 2^24), taken from the previous product
    assign amp_sum = prod_reg + (PW'(1) << 23);

    always_comb
    begin
        unique case (ctl.op)
            ests_pkg::MUL_AMP:
            begin
                op_a = env;
                op_b = peak;
            end
            ests_pkg::MUL_MAG:
            begin
                op_a = EW'(amp_sum[PW-1:24]);
                op_b = rom;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            prod_reg <= PW'(op_a) * PW'(op_b);
        end
    end

    assign prod = prod_reg;

endmodule

@@ rtl/enveloped_sine_tone_generator.sv @@
// An accepted item passes through states S_AMP, S_MAG and S_OUT before its result is loaded into the output register.
// The single multiplier is used twice per item (peak times envelope, then amplitude times sine),
// and the input takes no new item until the result of the last one is loaded into the output register.
// Output stalls hold the result register and keep the block busy.
// Reset (rst_n low, asynchronous): registers to their default values, counter,
// phase and envelope to zero, output empty. No clearing pass.
`include "assert_macros.svh"

module enveloped_sine_tone_generator #(
    parameter int PHASE_BITS      = 32,
    parameter int SINE_TABLE_BITS = 10,
    parameter int SAMPLE_BITS     = 16,
    parameter int COUNT_BITS      = 24
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  logic [7:0]                               s_axis_tdata,  // [0] restart
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]         m_axis_tdata,  // [SAMPLE_BITS-1:0] sample
    output logic                                     m_axis_tlast,
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [ests_pkg::ADDR_BITS-1:0]           paddr,
    input  logic [31:0]                              pwdata,
    output logic [31:0]                              prdata,
    output logic                                     pready
);

    localparam int OUT_W   = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int EW      = ests_pkg::ENV_BITS;
    localparam int PW      = ests_pkg::PROD_BITS;
    localparam int LW      = ests_pkg::LEN_BITS;
    localparam int WIDE    = ((COUNT_BITS > LW) ? COUNT_BITS : LW) + 2;
    localparam int MAG_SH  = 31 - SAMPLE_BITS;
    localparam logic [PW-1:0] MAG_RND = PW'(1) << (30 - SAMPLE_BITS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_AMP  = 2'd1;
    localparam logic [1:0] S_MAG  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    ests_pkg::cfg_t     cfg;
    ests_pkg::mul_ctl_t mul_ctl;

    logic [1:0]                   state_reg, state_next;
    logic [COUNT_BITS-1:0]        count_reg, count_next;
    logic [PHASE_BITS-1:0]        phase_reg, phase_next;
    logic [EW-1:0]                env_level_reg, env_level_next;
    logic [EW-1:0]                env_sel_reg;
    logic                         neg_reg;
    logic                         last_reg;
    logic                         out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0]       out_data_reg;
    logic                         out_last_reg;

    logic                         accept;
    logic                         restart;
    logic [COUNT_BITS-1:0]        cur_count;
    logic [PHASE_BITS-1:0]        cur_phase;
    logic [EW-1:0]                cur_env;
    logic [WIDE-1:0]              i_w, total_w, a_end, s_end, d_end;
    logic                         done;
    logic [EW-1:0]                env_val, env_new;
    logic [EW:0]                  att_sum;
    logic [1:0]                   quad;
    logic [SINE_TABLE_BITS-1:0]   rom_addr;
    logic [ests_pkg::ROM_WORD-1:0] rom_data;
    logic [PW-1:0]                prod;
    logic [PW-1:0]                mag_sum;
    logic [SAMPLE_BITS-1:0]       mag;
    logic                         out_load;

    ests_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ests_rom #(
        .TABLE_BITS (SINE_TABLE_BITS)
    ) u_rom (
        .clk   (clk),
        .rd_en (accept),
        .addr  (rom_addr),
        .data  (rom_data)
    );

    ests_mul u_mul (
        .clk  (clk),
        .ctl  (mul_ctl),
        .env  (env_sel_reg),
        .peak (cfg.peak_amplitude),
        .rom  (rom_data),
        .prod (prod)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign restart       = s_axis_tdata[0];

    assign cur_count = restart ? '0 : count_reg;
    assign cur_phase = restart ? '0 : phase_reg;
    assign cur_env   = restart ? '0 : env_level_reg;

    assign i_w     = WIDE'(cur_count);
    assign total_w = WIDE'(cfg.total_samples);
    assign a_end   = WIDE'(cfg.attack_length);
    assign s_end   = a_end + WIDE'(cfg.sustain_length);
    assign d_end   = s_end + WIDE'(cfg.decay_length);
    assign done    = (i_w >= total_w);
    assign att_sum = (EW + 1)'(cur_env) + (EW + 1)'(cfg.attack_step);

    always_comb
    begin
        env_val = '0;
        env_new = '0;
        priority if (i_w < a_end)
        begin
            env_val = cur_env;
            env_new = (att_sum > (EW + 1)'(ests_pkg::ENV_ONE)) ? ests_pkg::ENV_ONE
                                                               : att_sum[EW-1:0];
        end
        else if (i_w < s_end)
        begin
            env_val = ests_pkg::ENV_ONE;
            env_new = ests_pkg::ENV_ONE;
        end
        else if (i_w < d_end)
        begin
            env_val = (i_w == s_end) ? ests_pkg::ENV_ONE : cur_env;
            env_new = (env_val > cfg.decay_step) ? env_val - cfg.decay_step : '0;
        end
        else
        begin
            env_val = '0;
            env_new = '0;
        end
    end

    assign quad     = cur_phase[PHASE_BITS-1 -: 2];
    assign rom_addr = quad[0] ? ~cur_phase[PHASE_BITS-3 -: SINE_TABLE_BITS]
                              : cur_phase[PHASE_BITS-3 -: SINE_TABLE_BITS];

    always_comb
    begin
        count_next     = count_reg;
        phase_next     = phase_reg;
        env_level_next = env_level_reg;
        if (accept)
        begin
            count_next     = cur_count;
            phase_next     = cur_phase;
            env_level_next = cur_env;
            if (!done)
            begin
                count_next     = (cur_count != '1) ? cur_count + 1'b1 : cur_count;
                phase_next     = cur_phase + PHASE_BITS'(cfg.phase_step);
                env_level_next = env_new;
            end
        end
    end

    always_comb
    begin
        mul_ctl.en = 1'b0;
        mul_ctl.op = ests_pkg::MUL_AMP;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_AMP;
                end
            end
            S_AMP:
            begin
                mul_ctl.en = 1'b1;
                mul_ctl.op = ests_pkg::MUL_AMP;
                state_next = S_MAG;
            end
            S_MAG:
            begin
                mul_ctl.en = 1'b1;
                mul_ctl.op = ests_pkg::MUL_MAG;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign mag_sum  = prod + MAG_RND;
    assign mag      = mag_sum[MAG_SH +: SAMPLE_BITS];
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (m_axis_tvalid && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            phase_reg     <= '0;
            env_level_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            phase_reg     <= phase_next;
            env_level_reg <= env_level_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // finished tone: zero envelope gives a zero sample
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            env_sel_reg <= done ? '0 : env_val;
            neg_reg     <= quad[1] && !done;
            last_reg    <= !done && ((i_w + 1'b1) == total_w);
        end
        if (out_load)
        begin
            out_data_reg <= neg_reg ? (~mag + 1'b1) : mag;
            out_last_reg <= last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'(out_data_reg);
    assign m_axis_tlast  = out_last_reg;

    `ASSERT_NEXT(a_accept_starts, accept, state_reg == S_AMP)
    `ASSERT_IMPL(a_env_bounded, 1'b1, env_level_reg <= ests_pkg::ENV_ONE)
    `ASSERT_NEXT(a_count_monotonic, accept && !restart, count_reg >= $past(count_reg))
    `ASSERT_IMPL(a_out_from_seq, $rose(m_axis_tvalid), $past(state_reg) == S_OUT)
    `ASSERT_IMPL(a_busy_while_mul, mul_ctl.en, !s_axis_tready)

endmodule

@@ tb/testbench.sv @@
module testbench;

    localparam int PHASE_W    = 32;
    localparam int TABLE_W    = 10;
    localparam int SAMPLE_W   = 16;
    localparam int COUNT_W    = 24;
    localparam int TABLE_SIZE = 1 << TABLE_W;
    localparam int CYCLE_LIMIT = 200000;

    localparam int STYLE_SHAPED = 0;
    localparam int STYLE_WIDE   = 1;
    localparam int STYLE_MAX    = 2;
    localparam int STYLE_MIN    = 3;

    localparam logic [24:0] UNITY = 25'h100_0000;
    localparam logic [63:0] Q30   = 64'd1 << 30;
    localparam logic [63:0] HALF_PI = 64'd1686629713;
    localparam logic [63:0] TAYLOR_DIV [5] = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

    typedef struct packed {
        logic [31:0] phase_step;
        logic [14:0] peak;
        logic [23:0] attack_len;
        logic [23:0] sustain_len;
        logic [23:0] decay_len;
        logic [24:0] attack_step;
        logic [24:0] decay_step;
        logic [23:0] total;
    } tone_settings_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } tone_out_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;  // [0] restart
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // [15:0] sample
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ests_pkg::ADDR_BITS-1:0] paddr = '0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    logic [14:0]       sine_q15 [TABLE_SIZE];
    tone_settings_t    tone_cfg;
    logic [COUNT_W-1:0] tone_count;
    logic [PHASE_W-1:0] tone_phase;
    logic [24:0]       tone_env;

    logic              restart_plan [$];
    tone_out_t         pending_tones [$];
    logic [31:0]       reg_plan [8];

    int  tx_idle_pct = 0;
    int  rx_stall_pct = 0;
    logic rx_hold = 1'b0;
    logic in_taken = 1'b0;
    int  mismatch_count = 0;
    int  cycle_count = 0;

    enveloped_sine_tone_generator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // quarter-wave magnitude, truncated Taylor series in Q2.30
    function automatic logic [14:0] quarter_sine(input int unsigned k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] v;
        x  = (HALF_PI * ((64'(k) << 1) + 64'd1)) >> (TABLE_W + 1);
        x2 = (x * x) >> 30;
        t  = Q30;
        for (int n = 0; n < 5; n++)
        begin
            t = Q30 - (((x2 * t) >> 30) / TAYLOR_DIV[n]);
        end
        s = (x * t) >> 30;
        v = (s + 64'd16384) >> 15;
        if (v > 64'd32767)
        begin
            v = 64'd32767;
        end
        return v[14:0];
    endfunction

    function automatic tone_out_t next_tone(input logic restart);
        tone_out_t   r;
        logic [25:0] a_end;
        logic [25:0] s_end;
        logic [25:0] d_end;
        logic [25:0] cnt;
        logic [25:0] rise;
        logic [24:0] env;
        logic [1:0]  quad;
        logic [TABLE_W-1:0] idx;
        logic [63:0] amp;
        logic [63:0] mag;
        logic [63:0] signed_mag;
        if (restart)
        begin
            tone_count = '0;
            tone_phase = '0;
            tone_env   = '0;
        end
        r.sample = '0;
        r.last   = 1'b0;
        if (tone_count >= tone_cfg.total)
        begin
            return r;
        end
        cnt   = 26'(tone_count);
        a_end = 26'(tone_cfg.attack_len);
        s_end = a_end + 26'(tone_cfg.sustain_len);
        d_end = s_end + 26'(tone_cfg.decay_len);
        if (cnt < a_end)
        begin
            env  = tone_env;
            rise = 26'(tone_env) + 26'(tone_cfg.attack_step);
            tone_env = (rise > 26'(UNITY)) ? UNITY : rise[24:0];
        end
        else if (cnt < s_end)
        begin
            env      = UNITY;
            tone_env = UNITY;
        end
        else if (cnt < d_end)
        begin
            env      = (cnt == s_end) ? UNITY : tone_env;
            tone_env = (env > tone_cfg.decay_step) ? env - tone_cfg.decay_step : '0;
        end
        else
        begin
            env      = '0;
            tone_env = '0;
        end
        quad = tone_phase[PHASE_W-1 -: 2];
        idx  = tone_phase[PHASE_W-3 -: TABLE_W];
        if (quad[0])
        begin
            idx = ~idx;
        end
        amp = (64'(tone_cfg.peak) * 64'(env) + (64'd1 << 23)) >> 24;
        mag = (amp * 64'(sine_q15[idx]) + (64'd1 << (30 - SAMPLE_W))) >> (31 - SAMPLE_W);
        signed_mag = quad[1] ? (64'd0 - mag) : mag;
        r.sample = signed_mag[SAMPLE_W-1:0];
        r.last   = ({1'b0, tone_count} + 25'd1) == {1'b0, tone_cfg.total};
        tone_phase = tone_phase + tone_cfg.phase_step;
        if (tone_count < tone_cfg.total && tone_count != {COUNT_W{1'b1}})
        begin
            tone_count = tone_count + 1'b1;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // sender
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else if (!s_axis_tvalid || in_taken)
        begin
            if (restart_plan.size() != 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {7'd0, restart_plan.pop_front()};
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (rx_hold)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge clk)
    begin : tone_monitor
        tone_out_t want;
        if (!rst_n)
        begin
            in_taken <= 1'b0;
        end
        else
        begin
            in_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
            begin
                pending_tones.push_back(next_tone(s_axis_tdata[0]));
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_tones.size() == 0)
                begin
                    report_mismatch("result with no item outstanding");
                end
                else
                begin
                    want = pending_tones.pop_front();
                    if (m_axis_tdata[SAMPLE_W-1:0] !== want.sample)
                    begin
                        report_mismatch($sformatf("sample %h, predicted %h",
                            m_axis_tdata[SAMPLE_W-1:0], want.sample));
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        report_mismatch($sformatf("tlast %b, predicted %b",
                            m_axis_tlast, want.last));
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            ests_pkg::REG_PHASE_STEP:     tone_cfg.phase_step  = value;
            ests_pkg::REG_PEAK_AMPLITUDE: tone_cfg.peak        = value[14:0];
            ests_pkg::REG_ATTACK_LENGTH:  tone_cfg.attack_len  = value[23:0];
            ests_pkg::REG_SUSTAIN_LENGTH: tone_cfg.sustain_len = value[23:0];
            ests_pkg::REG_DECAY_LENGTH:   tone_cfg.decay_len   = value[23:0];
            ests_pkg::REG_ATTACK_STEP:    tone_cfg.attack_step = value[24:0];
            ests_pkg::REG_DECAY_STEP:     tone_cfg.decay_step  = value[24:0];
            ests_pkg::REG_TOTAL_SAMPLES:  tone_cfg.total       = value[23:0];
            default: ;
        endcase
    endtask

    task automatic program_registers();
        for (int i = 0; i < 8; i++)
        begin
            apb_write(3'(i), reg_plan[i]);
        end
    endtask

    function automatic logic [31:0] ramp_step(input logic [31:0] len);
        logic [31:0] step;
        case ($urandom_range(4))
            0: step = 32'd0;
            1: step = 32'(UNITY);
            2: step = $urandom_range(32'(UNITY));
            default:
            begin
                step = (len == 0) ? 32'(UNITY) : 32'(UNITY) / len + $urandom_range(100000);
                if (step > 32'(UNITY))
                begin
                    step = 32'(UNITY);
                end
            end
        endcase
        return step;
    endfunction

    task automatic plan_settings(input int style);
        logic [31:0] a_len;
        logic [31:0] s_len;
        logic [31:0] d_len;
        case ($urandom_range(5))
            0: reg_plan[ests_pkg::REG_PHASE_STEP] = 32'd0;
            1: reg_plan[ests_pkg::REG_PHASE_STEP] = 32'hFFFF_FFFF;
            2: reg_plan[ests_pkg::REG_PHASE_STEP] = $urandom_range(32'h0100_0000);
            default: reg_plan[ests_pkg::REG_PHASE_STEP] = $urandom;
        endcase
        case ($urandom_range(4))
            0: reg_plan[ests_pkg::REG_PEAK_AMPLITUDE] = 32'd0;
            1: reg_plan[ests_pkg::REG_PEAK_AMPLITUDE] = 32'd32767;
            default: reg_plan[ests_pkg::REG_PEAK_AMPLITUDE] = $urandom_range(32767);
        endcase
        if (style == STYLE_SHAPED)
        begin
            a_len = $urandom_range(10);
            s_len = $urandom_range(6);
            d_len = $urandom_range(10);
            reg_plan[ests_pkg::REG_TOTAL_SAMPLES] = ($urandom_range(3) == 0) ?
                1 + $urandom_range(a_len + s_len + d_len) :
                a_len + s_len + d_len + $urandom_range(4);
            if (reg_plan[ests_pkg::REG_TOTAL_SAMPLES] == 0)
            begin
                reg_plan[ests_pkg::REG_TOTAL_SAMPLES] = 1;
            end
        end
        else
        begin
            a_len = $urandom_range(1) ? $urandom_range(24'hFF_FFFF) : $urandom_range(8);
            s_len = $urandom_range(1) ? $urandom_range(24'hFF_FFFF) : $urandom_range(8);
            d_len = $urandom_range(1) ? $urandom_range(24'hFF_FFFF) : $urandom_range(8);
            reg_plan[ests_pkg::REG_TOTAL_SAMPLES] = $urandom_range(1) ?
                $urandom_range(24'hFF_FFFF, 1) : $urandom_range(48, 1);
        end
        reg_plan[ests_pkg::REG_ATTACK_LENGTH]  = a_len;
        reg_plan[ests_pkg::REG_SUSTAIN_LENGTH] = s_len;
        reg_plan[ests_pkg::REG_DECAY_LENGTH]   = d_len;
        reg_plan[ests_pkg::REG_ATTACK_STEP]    = ramp_step(a_len);
        reg_plan[ests_pkg::REG_DECAY_STEP]     = ramp_step(d_len);
        if (style == STYLE_MAX)
        begin
            reg_plan[ests_pkg::REG_PHASE_STEP]     = 32'hFFFF_FFFF;
            reg_plan[ests_pkg::REG_PEAK_AMPLITUDE] = 32'd32767;
            reg_plan[ests_pkg::REG_ATTACK_LENGTH]  = 32'hFF_FFFF;
            reg_plan[ests_pkg::REG_SUSTAIN_LENGTH] = 32'hFF_FFFF;
            reg_plan[ests_pkg::REG_DECAY_LENGTH]   = 32'hFF_FFFF;
            reg_plan[ests_pkg::REG_ATTACK_STEP]    = 32'(UNITY);
            reg_plan[ests_pkg::REG_DECAY_STEP]     = 32'(UNITY);
            reg_plan[ests_pkg::REG_TOTAL_SAMPLES]  = 32'hFF_FFFF;
        end
        else if (style == STYLE_MIN)
        begin
            reg_plan[ests_pkg::REG_PHASE_STEP]     = 32'd0;
            reg_plan[ests_pkg::REG_PEAK_AMPLITUDE] = 32'd0;
            reg_plan[ests_pkg::REG_ATTACK_LENGTH]  = 32'd0;
            reg_plan[ests_pkg::REG_SUSTAIN_LENGTH] = 32'd0;
            reg_plan[ests_pkg::REG_DECAY_LENGTH]   = 32'd0;
            reg_plan[ests_pkg::REG_ATTACK_STEP]    = 32'd0;
            reg_plan[ests_pkg::REG_DECAY_STEP]     = 32'd0;
            reg_plan[ests_pkg::REG_TOTAL_SAMPLES]  = 32'd1;
        end
    endtask

    // mostly whole tones from a restart, some cut short, some stray items
    task automatic queue_tones(input int n_items);
        int pushed;
        int run_len;
        pushed = 0;
        while (pushed < n_items)
        begin
            if ($urandom_range(9) == 0)
            begin
                restart_plan.push_back(1'($urandom_range(1)));
                pushed++;
            end
            else
            begin
                restart_plan.push_back(1'b1);
                run_len = (tone_cfg.total < 60) ? int'(tone_cfg.total) + $urandom_range(3)
                                                : $urandom_range(60);
                if ($urandom_range(7) == 0)
                begin
                    run_len = $urandom_range(run_len);
                end
                repeat (run_len)
                begin
                    restart_plan.push_back(1'b0);
                end
                pushed += run_len + 1;
            end
        end
    endtask

    task automatic wait_idle();
        while (restart_plan.size() != 0 || s_axis_tvalid || pending_tones.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic set_traffic(input int tx_pct, input int rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
    endtask

    initial
    begin
        for (int k = 0; k < TABLE_SIZE; k++)
        begin
            sine_q15[k] = quarter_sine(k);
        end
        tone_cfg.phase_step  = ests_pkg::RST_PHASE_STEP;
        tone_cfg.peak        = ests_pkg::RST_PEAK_AMPLITUDE;
        tone_cfg.attack_len  = ests_pkg::RST_ATTACK_LENGTH;
        tone_cfg.sustain_len = ests_pkg::RST_SUSTAIN_LENGTH;
        tone_cfg.decay_len   = ests_pkg::RST_DECAY_LENGTH;
        tone_cfg.attack_step = ests_pkg::RST_ATTACK_STEP;
        tone_cfg.decay_step  = ests_pkg::RST_DECAY_STEP;
        tone_cfg.total       = ests_pkg::RST_TOTAL_SAMPLES;
        tone_count = '0;
        tone_phase = '0;
        tone_env   = '0;

        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // power-on settings: two items without restart, then a restart
        restart_plan.push_back(1'b0);
        restart_plan.push_back(1'b0);
        restart_plan.push_back(1'b1);
        restart_plan.push_back(1'b0);
        restart_plan.push_back(1'b0);
        wait_idle();

        // short tone: attack clamps at unity, decay floors at zero, tone ends
        reg_plan[ests_pkg::REG_PHASE_STEP]     = 32'h4000_0000;
        reg_plan[ests_pkg::REG_PEAK_AMPLITUDE] = 32'd32767;
        reg_plan[ests_pkg::REG_ATTACK_LENGTH]  = 32'd3;
        reg_plan[ests_pkg::REG_SUSTAIN_LENGTH] = 32'd2;
        reg_plan[ests_pkg::REG_DECAY_LENGTH]   = 32'd3;
        reg_plan[ests_pkg::REG_ATTACK_STEP]    = 32'h60_0000;
        reg_plan[ests_pkg::REG_DECAY_STEP]     = 32'h90_0000;
        reg_plan[ests_pkg::REG_TOTAL_SAMPLES]  = 32'd10;
        program_registers();
        restart_plan.push_back(1'b1);
        repeat (11) restart_plan.push_back(1'b0);
        restart_plan.push_back(1'b1);
        wait_idle();

        // zero-length tone: always finished
        reg_plan[ests_pkg::REG_PHASE_STEP]     = 32'h8000_0000;
        reg_plan[ests_pkg::REG_PEAK_AMPLITUDE] = 32'd1;
        reg_plan[ests_pkg::REG_ATTACK_LENGTH]  = 32'd1;
        reg_plan[ests_pkg::REG_SUSTAIN_LENGTH] = 32'd1;
        reg_plan[ests_pkg::REG_DECAY_LENGTH]   = 32'd1;
        reg_plan[ests_pkg::REG_ATTACK_STEP]    = 32'(UNITY);
        reg_plan[ests_pkg::REG_DECAY_STEP]     = 32'(UNITY);
        reg_plan[ests_pkg::REG_TOTAL_SAMPLES]  = 32'd0;
        program_registers();
        restart_plan.push_back(1'b1);
        restart_plan.push_back(1'b0);
        restart_plan.push_back(1'b0);
        wait_idle();

        for (int p = 0; p < 12; p++)
        begin
            case (p % 4)
                0: set_traffic(0, 0);
                1: set_traffic(88, 0);
                2: set_traffic(0, 88);
                default: set_traffic(7, 7);
            endcase
            if (p == 4)
            begin
                plan_settings(STYLE_MAX);
            end
            else if (p == 9)
            begin
                plan_settings(STYLE_MIN);
            end
            else
            begin
                plan_settings((p % 2 == 0) ? STYLE_SHAPED : STYLE_WIDE);
            end
            program_registers();
            queue_tones(60);
            if (p == 8)
            begin
                // output held off while items keep coming; input must back up
                @(posedge clk);
                rx_hold <= 1'b1;
                repeat (200) @(posedge clk);
                rx_hold <= 1'b0;
            end
            wait_idle();
        end

        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
